FILE: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Result field widths, command and status codes, microcode words and the
// microcode program itself.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Result and command field widths
    localparam int NUM_W       = 34;
    localparam int DEN_W       = 33;
    localparam int OUT_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DEN  = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    // Datapath operations driven by one microcode word
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_MUL_A     = 4'd2,
        OP_MUL_B     = 4'd3,
        OP_MUL_C     = 4'd4,
        OP_COMBINE   = 4'd5,
        OP_GCD       = 4'd6,
        OP_DIV_SETUP = 4'd7,
        OP_DIV       = 4'd8,
        OP_ZERO      = 4'd9,
        OP_EMIT      = 4'd10
    } dp_op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_INPUT = 3'd2,
        C_BAD      = 3'd3,
        C_NUM_ZERO = 3'd4,
        C_GCD_BUSY = 3'd5,
        C_CNT_NZ   = 3'd6,
        C_OUT_BUSY = 3'd7
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_CHECK   = 4'd1;
    localparam step_t STEP_MUL_A   = 4'd2;
    localparam step_t STEP_MUL_B   = 4'd3;
    localparam step_t STEP_MUL_C   = 4'd4;
    localparam step_t STEP_COMBINE = 4'd5;
    localparam step_t STEP_ZTEST   = 4'd6;
    localparam step_t STEP_GCD     = 4'd7;
    localparam step_t STEP_DSETUP  = 4'd8;
    localparam step_t STEP_DIV     = 4'd9;
    localparam step_t STEP_FINISH  = 4'd10;
    localparam step_t STEP_ZERO    = 4'd11;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  jump;
        step_t  next;
    } uword_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic bad;
        logic num_zero;
        logic gcd_busy;
        logic cnt_nz;
    } dp_flags_t;

    // Microcode program: one control word per step
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
        case (s)
            STEP_IDLE:    w = '{OP_LOAD,      C_NO_INPUT, STEP_IDLE,   STEP_CHECK};
            STEP_CHECK:   w = '{OP_NOP,       C_BAD,      STEP_ZERO,   STEP_MUL_A};
            STEP_MUL_A:   w = '{OP_MUL_A,     C_NONE,     STEP_IDLE,   STEP_MUL_B};
            STEP_MUL_B:   w = '{OP_MUL_B,     C_NONE,     STEP_IDLE,   STEP_MUL_C};
            STEP_MUL_C:   w = '{OP_MUL_C,     C_NONE,     STEP_IDLE,   STEP_COMBINE};
            STEP_COMBINE: w = '{OP_COMBINE,   C_NONE,     STEP_IDLE,   STEP_ZTEST};
            STEP_ZTEST:   w = '{OP_NOP,       C_NUM_ZERO, STEP_ZERO,   STEP_GCD};
            STEP_GCD:     w = '{OP_GCD,       C_GCD_BUSY, STEP_GCD,    STEP_DSETUP};
            STEP_DSETUP:  w = '{OP_DIV_SETUP, C_NONE,     STEP_IDLE,   STEP_DIV};
            STEP_DIV:     w = '{OP_DIV,       C_CNT_NZ,   STEP_DIV,    STEP_FINISH};
            STEP_FINISH:  w = '{OP_EMIT,      C_OUT_BUSY, STEP_FINISH, STEP_IDLE};
            STEP_ZERO:    w = '{OP_ZERO,      C_NONE,     STEP_IDLE,   STEP_FINISH};
            default:      w = '{OP_NOP,       C_ALWAYS,   STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: exact add, subtract, multiply and divide of fractions
// Takes two raw fractions and a command, returns the reduced result with a
// positive denominator and a status code.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A zero denominator or a division by a
// zero fraction returns 0/1 with its status through the check, zero and
// finish steps; a zero result runs the check, multiply A, B and C, combine,
// zero test, zero and finish steps. Otherwise an item runs the steps up to
// the zero test, G binary gcd steps (G data dependent), the division setup,
// a one-bit-per-cycle division of the numerator and denominator by the gcd
// and the finish step. All work is ordered by a microcode program stepping
// a single datapath with one shared multiplier. A finished result waits in
// the output register; s_tready rises again once it has been placed there.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter  int OPERAND_WIDTH = 16,
    localparam int IN_TDATA_W    = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_TDATA_W-1:0]              s_tdata,   // a_num, a_den, b_num, b_den
    input  logic [rau_pkg::CMD_W-1:0]          s_tuser,   // command
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rau_pkg::OUT_TDATA_W-1:0]    m_tdata,   // result_num, result_den
    output logic [rau_pkg::STATUS_W-1:0]       m_tuser    // status
);

    localparam int W = OPERAND_WIDTH;

    rau_pkg::dp_op_t    op;
    rau_pkg::dp_flags_t flags;
    logic               idle;
    logic               out_busy;
    logic               out_load;
    logic signed [W-1:0] a_num, a_den, b_num, b_den;
    logic [rau_pkg::NUM_W-1:0] result_num;
    logic [rau_pkg::DEN_W-1:0] result_den;
    rau_pkg::status_t   status;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic [rau_pkg::STATUS_W-1:0]    m_tuser_reg,  m_tuser_next;

    // Unpack the operand fields
    assign a_num = s_tdata[W-1:0];
    assign a_den = s_tdata[2*W-1:W];
    assign b_num = s_tdata[3*W-1:2*W];
    assign b_den = s_tdata[4*W-1:3*W];

    rau_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .flags    (flags),
        .op       (op),
        .idle     (idle)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .op         (op),
        .command    (s_tuser),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .flags      (flags),
        .result_num (result_num),
        .result_den (result_den),
        .status     (status)
    );

    assign s_tready = idle;

    // Output register: load on emit when free, drop on transaction
    always_comb
    begin
        out_busy      = m_tvalid_reg && !m_tready;
        out_load      = (op == rau_pkg::OP_EMIT) && !out_busy;
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = out_load ? rau_pkg::OUT_TDATA_W'({result_den, result_num})
                                 : m_tdata_reg;
        m_tuser_next  = out_load ? status : m_tuser_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: src/rau_seq.sv
// ----------------------------------------------------------------------------
// rau_seq: microcode sequencer
// Step counter over the microcode program, with conditional jumps on the
// datapath flags, the input valid and the output register occupancy.
// ----------------------------------------------------------------------------
module rau_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_busy,
    input  rau_pkg::dp_flags_t flags,
    output rau_pkg::dp_op_t    op,
    output logic               idle
);

    rau_pkg::step_t  step_reg;
    rau_pkg::step_t  step_next;
    rau_pkg::uword_t uword;
    logic            cond_true;

    // Fetch the control word for the current step
    always_comb
    begin
        uword = rau_pkg::ucode_rom(step_reg);
        op    = uword.op;
        idle  = (step_reg == rau_pkg::STEP_IDLE);
    end

    // Evaluate the jump condition and pick the next step
    always_comb
    begin
        case (uword.cond)
            rau_pkg::C_NONE:     cond_true = 1'b0;
            rau_pkg::C_ALWAYS:   cond_true = 1'b1;
            rau_pkg::C_NO_INPUT: cond_true = !in_valid;
            rau_pkg::C_BAD:      cond_true = flags.bad;
            rau_pkg::C_NUM_ZERO: cond_true = flags.num_zero;
            rau_pkg::C_GCD_BUSY: cond_true = flags.gcd_busy;
            rau_pkg::C_CNT_NZ:   cond_true = flags.cnt_nz;
            rau_pkg::C_OUT_BUSY: cond_true = out_busy;
            default:             cond_true = 1'b0;
        endcase
        step_next = cond_true ? uword.jump : uword.next;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rau_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: src/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, binary gcd and
// exact division lanes
// Each microcode operation updates a fixed set of registers; nothing here
// decides the order of work.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            clk,
    input  rau_pkg::dp_op_t                 op,
    input  logic [rau_pkg::CMD_W-1:0]       command,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output rau_pkg::dp_flags_t              flags,
    output logic [rau_pkg::NUM_W-1:0]       result_num,
    output logic [rau_pkg::DEN_W-1:0]       result_den,
    output rau_pkg::status_t                status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int CW = $clog2(MW + 1);
    localparam int XW = (MW > rau_pkg::NUM_W) ? MW : rau_pkg::NUM_W;

    rau_pkg::cmd_t    cmd_reg,    cmd_next;
    rau_pkg::status_t status_reg, status_next;
    logic             a_neg_reg,  a_neg_next;
    logic             b_neg_reg,  b_neg_next;
    logic [W-1:0]     an_reg,     an_next;
    logic [W-1:0]     ad_reg,     ad_next;
    logic [W-1:0]     bn_reg,     bn_next;
    logic [W-1:0]     bd_reg,     bd_next;
    logic [PW-1:0]    t1_reg,     t1_next;
    logic [PW-1:0]    t2_reg,     t2_next;
    logic [MW-1:0]    n_reg,      n_next;
    logic [MW-1:0]    d_reg,      d_next;
    logic             neg_reg,    neg_next;
    logic [MW-1:0]    u_reg,      u_next;
    logic [MW-1:0]    v_reg,      v_next;
    logic [MW-1:0]    rem_n_reg,  rem_n_next;
    logic [MW-1:0]    rem_d_reg,  rem_d_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;

    logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
    logic [W-1:0]  mul_x, mul_y;
    logic [PW-1:0] mul_p;
    logic [MW-1:0] t1x, t2x, sum, diff;
    logic          s1, s2;
    logic [MW-1:0] comb_num;
    logic          comb_neg;
    logic [MW:0]   tn, td, gx, tn_sub, td_sub;
    logic          qn, qd;
    logic [XW-1:0] n_ext, n_signed, d_ext;

    // Split raw operands into magnitudes
    always_comb
    begin
        an_mag = a_num[W-1] ? W'(-a_num) : W'(a_num);
        ad_mag = a_den[W-1] ? W'(-a_den) : W'(a_den);
        bn_mag = b_num[W-1] ? W'(-b_num) : W'(b_num);
        bd_mag = b_den[W-1] ? W'(-b_den) : W'(b_den);
    end

    // Shared multiplier operand selection
    always_comb
    begin
        case (op)
            rau_pkg::OP_MUL_A:
            begin
                mul_x = an_reg;
                mul_y = (cmd_reg == rau_pkg::CMD_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::OP_MUL_B:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            default:
            begin
                mul_x = ad_reg;
                mul_y = (cmd_reg == rau_pkg::CMD_DIV) ? bn_reg : bd_reg;
            end
        endcase
        mul_p = PW'(mul_x) * PW'(mul_y);
    end

    // Signed combine of the cross products
    always_comb
    begin
        t1x  = MW'(t1_reg);
        t2x  = MW'(t2_reg);
        sum  = t1x + t2x;
        diff = t1x - t2x;
        s1   = a_neg_reg && (t1_reg != '0);
        s2   = ((cmd_reg == rau_pkg::CMD_SUB) ? !b_neg_reg : b_neg_reg) && (t2_reg != '0);
        if (cmd_reg == rau_pkg::CMD_MUL || cmd_reg == rau_pkg::CMD_DIV)
        begin
            comb_num = t1x;
            comb_neg = a_neg_reg ^ b_neg_reg;
        end
        else if (s1 == s2)
        begin
            comb_num = sum;
            comb_neg = s1;
        end
        else if (t1_reg >= t2_reg)
        begin
            comb_num = diff;
            comb_neg = s1;
        end
        else
        begin
            comb_num = -diff;
            comb_neg = s2;
        end
    end

    // Restoring division lanes, numerator and denominator by the same gcd
    always_comb
    begin
        gx     = {1'b0, u_reg};
        tn     = {rem_n_reg, n_reg[MW-1]};
        td     = {rem_d_reg, d_reg[MW-1]};
        tn_sub = tn - gx;
        td_sub = td - gx;
        qn     = (tn >= gx);
        qd     = (td >= gx);
    end

    // Register updates per microcode operation
    always_comb
    begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        a_neg_next  = a_neg_reg;
        b_neg_next  = b_neg_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        neg_next    = neg_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        rem_n_next  = rem_n_reg;
        rem_d_next  = rem_d_reg;
        cnt_next    = cnt_reg;
        case (op)
            rau_pkg::OP_LOAD:
            begin
                cmd_next   = rau_pkg::cmd_t'(command);
                a_neg_next = a_num[W-1] ^ a_den[W-1];
                b_neg_next = b_num[W-1] ^ b_den[W-1];
                an_next    = an_mag;
                ad_next    = ad_mag;
                bn_next    = bn_mag;
                bd_next    = bd_mag;
                if (a_den == '0 || b_den == '0)
                begin
                    status_next = rau_pkg::ST_BAD_DEN;
                end
                else if (rau_pkg::cmd_t'(command) == rau_pkg::CMD_DIV && b_num == '0)
                begin
                    status_next = rau_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    status_next = rau_pkg::ST_OK;
                end
            end
            rau_pkg::OP_MUL_A:
            begin
                t1_next = mul_p;
            end
            rau_pkg::OP_MUL_B:
            begin
                t2_next = mul_p;
            end
            rau_pkg::OP_MUL_C:
            begin
                d_next = MW'(mul_p);
                v_next = MW'(mul_p);
            end
            rau_pkg::OP_COMBINE:
            begin
                n_next   = comb_num;
                u_next   = comb_num;
                neg_next = comb_neg;
                cnt_next = '0;
            end
            rau_pkg::OP_GCD:
            begin
                // one binary gcd step; common factors of two are counted
                if (u_reg != v_reg)
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_next   = u_reg >> 1;
                        v_next   = v_reg >> 1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (!u_reg[0])
                    begin
                        u_next = u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_next = v_reg >> 1;
                    end
                    else if (u_reg > v_reg)
                    begin
                        u_next = u_reg - v_reg;
                    end
                    else
                    begin
                        v_next = v_reg - u_reg;
                    end
                end
            end
            rau_pkg::OP_DIV_SETUP:
            begin
                u_next     = u_reg << cnt_reg;
                rem_n_next = '0;
                rem_d_next = '0;
                cnt_next   = CW'(MW - 1);
            end
            rau_pkg::OP_DIV:
            begin
                n_next     = {n_reg[MW-2:0], qn};
                d_next     = {d_reg[MW-2:0], qd};
                rem_n_next = qn ? tn_sub[MW-1:0] : tn[MW-1:0];
                rem_d_next = qd ? td_sub[MW-1:0] : td[MW-1:0];
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            rau_pkg::OP_ZERO:
            begin
                n_next   = '0;
                d_next   = MW'(1);
                neg_next = 1'b0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Working registers, payload only
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        a_neg_reg  <= a_neg_next;
        b_neg_reg  <= b_neg_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        neg_reg    <= neg_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        rem_n_reg  <= rem_n_next;
        rem_d_reg  <= rem_d_next;
        cnt_reg    <= cnt_next;
    end

    // Flags for the sequencer
    always_comb
    begin
        flags.bad      = (status_reg != rau_pkg::ST_OK);
        flags.num_zero = (n_reg == '0);
        flags.gcd_busy = (u_reg != v_reg);
        flags.cnt_nz   = (cnt_reg != '0);
    end

    // Apply the sign and trim to the result fields
    always_comb
    begin
        n_ext      = XW'(n_reg);
        n_signed   = neg_reg ? (~n_ext + XW'(1)) : n_ext;
        d_ext      = XW'(d_reg);
        result_num = n_signed[rau_pkg::NUM_W-1:0];
        result_den = d_ext[rau_pkg::DEN_W-1:0];
        status     = status_reg;
    end

endmodule

FILE: src/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [rau_pkg::STATUS_W-1:0]    m_tuser
);

    logic [rau_pkg::NUM_W-1:0] num;
    logic [rau_pkg::DEN_W-1:0] den;

    assign num = m_tdata[rau_pkg::NUM_W-1:0];
    assign den = m_tdata[rau_pkg::NUM_W+rau_pkg::DEN_W-1:rau_pkg::NUM_W];

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item in progress");

    // Error results are reported as 0/1
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rau_pkg::ST_OK) |-> (num == '0) && (den == 1))
        else $error("error result not 0/1");

    // A zero result is normalised to 0/1
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rau_pkg::ST_OK) && (num == '0) |-> (den == 1))
        else $error("zero result with denominator other than one");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Drives operand pairs and a command on the slave stream. Each result on the
// master stream is checked against the table's given result, if any, or a
// fraction predictor written here: the operands are reduced, the operation
// is worked exactly and the result reduced again. A short directed table
// leads; then random items under three settings of idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int OPW          = 16;
    localparam int IN_W         = ((4 * OPW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 256;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int REPORT_MAX   = 10;

    // Expected result of one transaction
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        status_t          status;
    } rat_result_t;

    // One directed case; the result is given only where it is obvious
    typedef struct {
        cmd_t    cmd;
        shortint an;
        shortint ad;
        shortint bn;
        shortint bd;
        bit      given;
        longint  e_num;
        longint  e_den;
        status_t e_status;
    } operand_row_t;

    localparam int ROWS = 24;

    operand_row_t directed_rows [ROWS] = '{
        '{CMD_ADD,      1,      2,      1,      3, 0,          0, 1, ST_OK},
        '{CMD_SUB,      3,      4,      3,      4, 1,          0, 1, ST_OK},
        '{CMD_MUL,      0,     -7,      5,      3, 1,          0, 1, ST_OK},
        '{CMD_DIV,      2,      3,      0,      5, 1,          0, 1, ST_DIV_ZERO},
        '{CMD_ADD,      1,      0,      1,      1, 1,          0, 1, ST_BAD_DEN},
        '{CMD_SUB,      5,      3,      7,      0, 1,          0, 1, ST_BAD_DEN},
        '{CMD_DIV,      1,      0,      0,      0, 1,          0, 1, ST_BAD_DEN},
        '{CMD_MUL, -32768, -32768,      1,      1, 1,          1, 1, ST_OK},
        '{CMD_MUL,  32767,      1,  32767,      1, 1, 1073676289, 1, ST_OK},
        '{CMD_MUL, -32768,      1, -32768,      1, 1, 1073741824, 1, ST_OK},
        '{CMD_DIV, -32768,      1,      1, -32768, 1, 1073741824, 1, ST_OK},
        '{CMD_ADD,  32767,      1, -32768,      1, 1,         -1, 1, ST_OK},
        '{CMD_ADD,      1,  32767,      1, -32768, 0,          0, 1, ST_OK},
        '{CMD_ADD,      3,     -6,      0,     -5, 0,          0, 1, ST_OK},
        '{CMD_DIV,      2,      3,     -4,      5, 0,          0, 1, ST_OK},
        '{CMD_SUB,  32767, -32768, -32768,  32767, 0,          0, 1, ST_OK},
        '{CMD_MUL,      1,  32767,      1, -32768, 0,          0, 1, ST_OK},
        '{CMD_DIV,      1, -32768,  32767,  32767, 0,          0, 1, ST_OK},
        '{CMD_SUB,     -1,     -1,     -1,     -1, 1,          0, 1, ST_OK},
        '{CMD_DIV,      0,     -3,     -9,      6, 1,          0, 1, ST_OK},
        '{CMD_ADD, -32768, -32768, -32768, -32768, 1,          2, 1, ST_OK},
        '{CMD_DIV,      6,      4,      9,      6, 1,          1, 1, ST_OK},
        '{CMD_ADD,      0,      1,      0,     -1, 1,          0, 1, ST_OK},
        '{CMD_DIV,      0,      0,      0,      5, 1,          0, 1, ST_BAD_DEN}
    };

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata  = '0;   // a_num, a_den, b_num, b_den
    logic [CMD_W-1:0]       s_tuser  = '0;   // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // result_num, result_den
    logic [STATUS_W-1:0]    m_tuser;         // status

    rat_result_t expected_results [$];
    int          send_idle_pct = 23;
    int          recv_idle_pct = 48;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;

    rational_arith_unit #(.OPERAND_WIDTH(OPW)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fraction predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned gcd_mag(input longint unsigned x,
                                                input longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Divide out the gcd; a zero numerator always becomes 0/1
    function automatic void reduce_frac(inout bit neg, inout longint unsigned num,
                                        inout longint unsigned den);
        longint unsigned g;
        if (num == 0)
        begin
            neg = 1'b0;
            den = 1;
        end
        else
        begin
            g   = gcd_mag(num, den);
            num = num / g;
            den = den / g;
        end
    endfunction

    // Split a raw operand into sign and magnitudes, then reduce it
    function automatic void load_operand(input logic signed [OPW-1:0] rn,
                                         input logic signed [OPW-1:0] rd,
                                         output bit neg, output longint unsigned num,
                                         output longint unsigned den);
        longint sn;
        longint sd;
        sn  = rn;
        sd  = rd;
        neg = (sn < 0) != (sd < 0);
        num = (sn < 0) ? -sn : sn;
        den = (sd < 0) ? -sd : sd;
        reduce_frac(neg, num, den);
    endfunction

    function automatic rat_result_t predict_rational(input cmd_t cmd,
                                                     input logic [IN_W-1:0] word);
        bit              a_neg, b_neg, s1, s2, r_neg;
        longint unsigned a_num, a_den, b_num, b_den, t1, t2, r_num, r_den;
        longint          signed_num;
        rat_result_t     res;
        r_neg      = 1'b0;
        r_num      = 0;
        r_den      = 1;
        res.status = ST_OK;
        if (word[2*OPW-1:OPW] == '0 || word[4*OPW-1:3*OPW] == '0)
            res.status = ST_BAD_DEN;
        else
        begin
            load_operand(word[OPW-1:0], word[2*OPW-1:OPW], a_neg, a_num, a_den);
            load_operand(word[3*OPW-1:2*OPW], word[4*OPW-1:3*OPW], b_neg, b_num, b_den);
            case (cmd)
                CMD_ADD, CMD_SUB:
                begin
                    // Cross-multiply, then add or subtract the signed magnitudes
                    t1 = a_num * b_den;
                    t2 = b_num * a_den;
                    s1 = (t1 == 0) ? 1'b0 : a_neg;
                    s2 = (t2 == 0) ? 1'b0 : ((cmd == CMD_SUB) ? !b_neg : b_neg);
                    if (s1 == s2)
                    begin
                        r_num = t1 + t2;
                        r_neg = s1;
                    end
                    else if (t1 >= t2)
                    begin
                        r_num = t1 - t2;
                        r_neg = s1;
                    end
                    else
                    begin
                        r_num = t2 - t1;
                        r_neg = s2;
                    end
                    r_den = a_den * b_den;
                end
                CMD_MUL:
                begin
                    r_num = a_num * b_num;
                    r_den = a_den * b_den;
                    r_neg = a_neg != b_neg;
                end
                default:
                begin
                    if (b_num == 0)
                        res.status = ST_DIV_ZERO;
                    else
                    begin
                        r_num = a_num * b_den;
                        r_den = a_den * b_num;
                        r_neg = a_neg != b_neg;
                    end
                end
            endcase
            reduce_frac(r_neg, r_num, r_den);
        end
        signed_num = r_neg ? -longint'(r_num) : longint'(r_num);
        res.num    = signed_num[NUM_W-1:0];
        res.den    = r_den[DEN_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random operands: full range, small values, extremes, shared factors
    // ------------------------------------------------------------------------
    function automatic logic [OPW-1:0] rand_field();
        logic [OPW-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = OPW'($urandom);
            4, 5, 6, 7: v = OPW'($urandom_range(32) - 16);
            8:
            begin
                case ($urandom_range(3))
                    0:       v = {1'b1, {(OPW-1){1'b0}}};
                    1:       v = {1'b0, {(OPW-1){1'b1}}};
                    2:       v = '1;
                    default: v = OPW'(1);
                endcase
            end
            default: v = OPW'($urandom_range(255) << $urandom_range(7));
        endcase
        return v;
    endfunction

    function automatic logic [IN_W-1:0] random_operands(input cmd_t cmd);
        logic [OPW-1:0] an, ad, bn, bd;
        an = rand_field();
        bn = rand_field();
        ad = ($urandom_range(29) == 0) ? '0 : rand_field();
        bd = ($urandom_range(29) == 0) ? '0 : rand_field();
        // Push some divisions towards a zero divisor
        if (cmd == CMD_DIV && $urandom_range(19) == 0)
            bn = '0;
        return {bd, bn, ad, an};
    endfunction

    // ------------------------------------------------------------------------
    // Slave side: hold the transaction until accepted, then log its result
    // ------------------------------------------------------------------------
    task automatic send_operands(input cmd_t cmd, input logic [IN_W-1:0] word,
                                 input rat_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(want);
    endtask

    initial
    begin
        operand_row_t    row;
        rat_result_t     want;
        logic [IN_W-1:0] word;
        cmd_t            cmd;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < ROWS; i++)
        begin
            row  = directed_rows[i];
            word = {row.bd, row.bn, row.ad, row.an};
            if (row.given)
            begin
                want.num    = NUM_W'(row.e_num);
                want.den    = DEN_W'(row.e_den);
                want.status = row.e_status;
            end
            else
                want = predict_rational(row.cmd, word);
            send_operands(row.cmd, word, want);
        end

        // Random part, in three idling phases
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 23;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cmd  = cmd_t'($urandom_range(3));
            word = random_operands(cmd);
            send_operands(cmd, word, predict_rational(cmd, word));
        end
        s_tvalid <= 1'b0;

        // Drain, then let the block settle
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[rational_arith_unit] OK");
        else
            $display("[rational_arith_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Master side: random back-pressure and result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
    endtask

    always @(posedge clk)
    begin
        rat_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result %0d: unexpected transaction, tdata %h tuser %0d",
                             results_seen, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[NUM_W-1:0] !== want.num)
                    report_mismatch("result_num", $signed(want.num),
                                    $signed(m_tdata[NUM_W-1:0]));
                if (m_tdata[NUM_W+DEN_W-1:NUM_W] !== want.den)
                    report_mismatch("result_den", want.den, m_tdata[NUM_W+DEN_W-1:NUM_W]);
                if (m_tuser !== want.status)
                    report_mismatch("status", want.status, m_tuser);
            end
            results_seen++;
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[rational_arith_unit] ERROR");
        $finish;
    end

endmodule
